>>> hw/rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types, widths and codes of the voxel ray walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

  // grid and fixed-point format
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int HEAD_FRAC   = 14;
  localparam int REACH_FRAC  = 8;

  // field widths
  localparam int ORIGIN_W    = 32;
  localparam int HEADING_W   = 16;
  localparam int REACH_W     = 16;
  localparam int CODE_W      = 8;
  localparam int OUT_COORD_W = 16;
  localparam int KIND_W      = 2;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int FLOOR_W     = 16;
  localparam int BUDGET_W    = 17;
  localparam int CROSS_W     = 32;

  localparam logic [BUDGET_W-1:0] BUDGET_MAX = '1;
  localparam logic [CROSS_W-1:0]  CROSS_MAX  = '1;

  // divider operands
  localparam int DIVIDEND_W  = FRAC_BITS + HEAD_FRAC + 1;
  localparam int DIVISOR_W   = HEADING_W;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

  // end-point arithmetic of the cell budget
  localparam int PROD_W      = HEADING_W + REACH_W + 1;
  localparam int END_SHIFT   = FRAC_BITS + HEAD_FRAC + REACH_FRAC;
  localparam int END_W       = 34 + ((HEAD_FRAC + REACH_FRAC > FRAC_BITS) ?
                                     (HEAD_FRAC + REACH_FRAC) : FRAC_BITS);
  localparam int DIFF_W      = 34;
  localparam int CMP_W       = ((COORD_BITS > FLOOR_W) ? COORD_BITS : FLOOR_W) + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CROSS_W-1:0]    cross_t;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_ANSWER = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_HIT     = 2'd1,
    KIND_MISS    = 2'd2
  } kind_t;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_EMPTY  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIQUID = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR  = 2'd2;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPAN,
    ST_NEAR,
    ST_NEAR_WAIT,
    ST_STEP,
    ST_STEP_WAIT,
    ST_CHECK,
    ST_ANSWER,
    ST_ADVANCE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                          operation;
    logic signed [ORIGIN_W-1:0]   origin_x;
    logic signed [ORIGIN_W-1:0]   origin_y;
    logic signed [ORIGIN_W-1:0]   origin_z;
    logic signed [HEADING_W-1:0]  heading_x;
    logic signed [HEADING_W-1:0]  heading_y;
    logic signed [HEADING_W-1:0]  heading_z;
    logic [REACH_W-1:0]           reach;
    logic [CODE_W-1:0]            block_code;
  } in_item_t;

  typedef struct packed {
    kind_t                         kind;
    logic signed [OUT_COORD_W-1:0] cell_x;
    logic signed [OUT_COORD_W-1:0] cell_y;
    logic signed [OUT_COORD_W-1:0] cell_z;
    logic signed [OUT_COORD_W-1:0] before_x;
    logic signed [OUT_COORD_W-1:0] before_y;
    logic signed [OUT_COORD_W-1:0] before_z;
    logic [CODE_W-1:0]             hit_code;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  // low output bits of a wrapped cell coordinate
  function automatic logic [OUT_COORD_W-1:0] out_coord(input coord_t c);
    logic [COORD_BITS+OUT_COORD_W-1:0] wide;
    wide = {{OUT_COORD_W{1'b0}}, c};
    return wide[OUT_COORD_W-1:0];
  endfunction

  // clamp a quotient to the crossing range
  function automatic cross_t sat_cross(input logic [DIVIDEND_W-1:0] q);
    logic [DIVIDEND_W+CROSS_W-1:0] wide;
    logic [DIVIDEND_W+CROSS_W-1:0] lim;
    wide = {{CROSS_W{1'b0}}, q};
    lim  = {{DIVIDEND_W{1'b0}}, CROSS_MAX};
    if (wide > lim) begin
      return CROSS_MAX;
    end
    return wide[CROSS_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vrt_in_if.sv
// ----------------------------------------------------------------------------
// vrt_in_if
// Valid/ready channel carrying start and answer items into the walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vrt_in_if;
  logic              valid;
  logic              ready;
  vrt_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/vrt_out_if.sv
// ----------------------------------------------------------------------------
// vrt_out_if
// Valid/ready channel carrying requests, hits and misses out of the walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vrt_out_if;
  logic               valid;
  logic               ready;
  vrt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/voxel_ray_traversal_3d.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d
// 3D grid ray walker that asks an outside voxel store for each cell it enters.
// ----------------------------------------------------------------------------
// start item: two divisions per axis (near boundary and step) on the one shared
//   divider, then the budget check, and the result loads in ST_EMIT
// answer item: ST_ANSWER, ST_ADVANCE and ST_EMIT to a lookup request, ST_ANSWER
//   and ST_EMIT to a hit or miss; the input opens again only back in ST_IDLE
// synchronous reset clears the walk state, loads register defaults, no sweep
`timescale 1ns / 1ps
`default_nettype none

module voxel_ray_traversal_3d (
  input  wire logic                              clk,
  input  wire logic                              rst,
  vrt_in_if.sink                                 items,
  vrt_out_if.source                              results,
  input  wire logic                              cfg_write,
  input  wire logic [vrt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [vrt_pkg::CFG_W-1:0]         cfg_data
);

  // configuration registers
  logic [vrt_pkg::CODE_W-1:0]         empty_code;
  logic [vrt_pkg::CODE_W-1:0]         liquid_code;
  logic signed [vrt_pkg::FLOOR_W-1:0] floor_level;

  // sequencer
  vrt_pkg::state_t state;
  vrt_pkg::state_t state_next;
  logic [1:0]      axis;

  // walk state
  vrt_pkg::coord_t              cur [3];
  vrt_pkg::coord_t              prev [3];
  vrt_pkg::cross_t              next_cross [3];
  vrt_pkg::cross_t              cross_step [3];
  logic [2:0]                   step_neg;
  logic [vrt_pkg::BUDGET_W-1:0] cells_left;
  logic                         awaiting;

  // set-up working registers
  vrt_pkg::in_item_t                  item;
  logic signed [vrt_pkg::PROD_W-1:0]  prod;
  logic [vrt_pkg::DIFF_W-1:0]         term;
  logic [vrt_pkg::BUDGET_W-1:0]       budget;

  // result waiting for the output register, and the output register
  vrt_pkg::out_item_t res;
  vrt_pkg::out_item_t out_q;
  logic               out_valid;
  logic               out_load;

  vrt_pkg::div_req_t div_req;
  vrt_pkg::div_rsp_t div_rsp;

  logic accept;
  assign accept = items.valid && items.ready;

  // ---------------------------------------------------------------- set-up
  logic signed [vrt_pkg::ORIGIN_W-1:0]  org_sel;
  logic signed [vrt_pkg::HEADING_W-1:0] head_sel;
  logic [vrt_pkg::DIVISOR_W-1:0]        mag;
  logic [vrt_pkg::FRAC_BITS-1:0]        frac;
  logic [vrt_pkg::FRAC_BITS:0]          near;
  logic signed [vrt_pkg::ORIGIN_W-1:0]  org_floor;
  vrt_pkg::coord_t                      cell0;
  logic signed [vrt_pkg::END_W-1:0]     end_pos;
  logic signed [vrt_pkg::END_W-1:0]     end_cell;
  logic signed [vrt_pkg::DIFF_W-1:0]    span;
  logic [vrt_pkg::DIFF_W:0]             budget_sum;

  always_comb begin
    case (axis)
      vrt_pkg::AXIS_X: begin
        org_sel  = item.origin_x;
        head_sel = item.heading_x;
      end
      vrt_pkg::AXIS_Y: begin
        org_sel  = item.origin_y;
        head_sel = item.heading_y;
      end
      default: begin
        org_sel  = item.origin_z;
        head_sel = item.heading_z;
      end
    endcase

    // magnitude of the heading, -32768 comes out as 32768
    mag  = head_sel[vrt_pkg::HEADING_W-1] ? vrt_pkg::DIVISOR_W'(-head_sel)
                                          : vrt_pkg::DIVISOR_W'(head_sel);
    frac = org_sel[vrt_pkg::FRAC_BITS-1:0];
    // distance to the first boundary in the step direction
    near = head_sel[vrt_pkg::HEADING_W-1] ? {1'b0, frac}
         : ((vrt_pkg::FRAC_BITS+1)'(1) << vrt_pkg::FRAC_BITS) - {1'b0, frac};

    org_floor = org_sel >>> vrt_pkg::FRAC_BITS;
    cell0     = vrt_pkg::COORD_BITS'(org_floor);

    // end cell = floor(origin + heading * reach), all in one exact word
    end_pos  = (vrt_pkg::END_W'(org_sel) <<< (vrt_pkg::HEAD_FRAC + vrt_pkg::REACH_FRAC))
             + (vrt_pkg::END_W'(prod) <<< vrt_pkg::FRAC_BITS);
    end_cell = end_pos >>> vrt_pkg::END_SHIFT;
    span     = vrt_pkg::DIFF_W'(end_cell) - vrt_pkg::DIFF_W'(org_floor);

    budget_sum = {1'b0, term} + (vrt_pkg::DIFF_W+1)'(budget);
  end

  // ------------------------------------------------------------ step logic
  logic [1:0]                         pick;
  vrt_pkg::coord_t                    cur_new [3];
  vrt_pkg::coord_t                    stepped;
  logic [vrt_pkg::CROSS_W:0]          cross_sum;
  vrt_pkg::cross_t                    cross_new;
  logic signed [vrt_pkg::CMP_W-1:0]   y_ext;
  logic signed [vrt_pkg::CMP_W-1:0]   floor_ext;
  logic                               below;

  always_comb begin
    // nearest boundary, ties go to z (or y when x and y tie below z)
    if (next_cross[0] < next_cross[1]) begin
      pick = (next_cross[0] < next_cross[2]) ? vrt_pkg::AXIS_X : vrt_pkg::AXIS_Z;
    end else begin
      pick = (next_cross[1] < next_cross[2]) ? vrt_pkg::AXIS_Y : vrt_pkg::AXIS_Z;
    end

    stepped = step_neg[pick] ? cur[pick] - 1'b1 : cur[pick] + 1'b1;
    for (int i = 0; i < 3; i++) begin
      cur_new[i] = (pick == 2'(i)) ? stepped : cur[i];
    end

    cross_sum = {1'b0, next_cross[pick]} + {1'b0, cross_step[pick]};
    cross_new = cross_sum[vrt_pkg::CROSS_W] ? vrt_pkg::CROSS_MAX
                                            : cross_sum[vrt_pkg::CROSS_W-1:0];

    y_ext     = vrt_pkg::CMP_W'(signed'(cur_new[1]));
    floor_ext = vrt_pkg::CMP_W'(floor_level);
    below     = y_ext < floor_ext;
  end

  // ---------------------------------------------------------- answer logic
  logic                         pass;
  logic [vrt_pkg::BUDGET_W-1:0] left_dec;

  assign pass     = (item.block_code == empty_code) || (item.block_code == liquid_code);
  assign left_dec = cells_left - 1'b1;

  vrt_pkg::out_item_t miss_item;
  vrt_pkg::out_item_t req_item;
  vrt_pkg::out_item_t hit_item;

  always_comb begin
    miss_item      = '0;
    miss_item.kind = vrt_pkg::KIND_MISS;

    req_item        = '0;
    req_item.kind   = vrt_pkg::KIND_REQUEST;
    req_item.cell_x = vrt_pkg::out_coord(cur_new[0]);
    req_item.cell_y = vrt_pkg::out_coord(cur_new[1]);
    req_item.cell_z = vrt_pkg::out_coord(cur_new[2]);

    hit_item          = '0;
    hit_item.kind     = vrt_pkg::KIND_HIT;
    hit_item.cell_x   = vrt_pkg::out_coord(cur[0]);
    hit_item.cell_y   = vrt_pkg::out_coord(cur[1]);
    hit_item.cell_z   = vrt_pkg::out_coord(cur[2]);
    hit_item.before_x = vrt_pkg::out_coord(prev[0]);
    hit_item.before_y = vrt_pkg::out_coord(prev[1]);
    hit_item.before_z = vrt_pkg::out_coord(prev[2]);
    hit_item.hit_code = item.block_code;
  end

  // ------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    items.ready      = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {near, vrt_pkg::HEAD_FRAC'(0)};
    div_req.divisor  = mag;

    case (state)
      vrt_pkg::ST_IDLE: begin
        items.ready = 1'b1;
        if (accept) begin
          if (items.data.operation == vrt_pkg::OP_START) begin
            state_next = vrt_pkg::ST_MUL;
          end else if (awaiting) begin
            state_next = vrt_pkg::ST_ANSWER;
          end
          // answer with no walk in flight: dropped
        end
      end
      vrt_pkg::ST_MUL:  state_next = vrt_pkg::ST_SPAN;
      vrt_pkg::ST_SPAN: state_next = vrt_pkg::ST_NEAR;
      vrt_pkg::ST_NEAR: begin
        div_req.start = 1'b1;
        state_next    = vrt_pkg::ST_NEAR_WAIT;
      end
      vrt_pkg::ST_NEAR_WAIT: begin
        if (div_rsp.done) begin
          state_next = vrt_pkg::ST_STEP;
        end
      end
      vrt_pkg::ST_STEP: begin
        div_req.start    = 1'b1;
        div_req.dividend = vrt_pkg::DIVIDEND_W'(1)
                           << (vrt_pkg::FRAC_BITS + vrt_pkg::HEAD_FRAC);
        state_next       = vrt_pkg::ST_STEP_WAIT;
      end
      vrt_pkg::ST_STEP_WAIT: begin
        if (div_rsp.done) begin
          state_next = (axis == vrt_pkg::AXIS_Z) ? vrt_pkg::ST_CHECK : vrt_pkg::ST_MUL;
        end
      end
      vrt_pkg::ST_CHECK: begin
        state_next = (budget == '0) ? vrt_pkg::ST_EMIT : vrt_pkg::ST_ADVANCE;
      end
      vrt_pkg::ST_ANSWER: begin
        state_next = (pass && left_dec != '0) ? vrt_pkg::ST_ADVANCE : vrt_pkg::ST_EMIT;
      end
      vrt_pkg::ST_ADVANCE: state_next = vrt_pkg::ST_EMIT;
      vrt_pkg::ST_EMIT: begin
        // hold here while the previous result still waits to transfer
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = vrt_pkg::ST_IDLE;
        end
      end
      default: state_next = vrt_pkg::ST_IDLE;
    endcase
  end

  vrt_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ----------------------------------------------------- control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_code  <= '0;
      liquid_code <= vrt_pkg::CODE_W'(1);
      floor_level <= '0;
      axis        <= vrt_pkg::AXIS_X;
      step_neg    <= '0;
      cells_left  <= '0;
      awaiting    <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur[i]        <= '0;
        prev[i]       <= '0;
        next_cross[i] <= '0;
        cross_step[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          vrt_pkg::CFG_EMPTY:  empty_code  <= cfg_data[vrt_pkg::CODE_W-1:0];
          vrt_pkg::CFG_LIQUID: liquid_code <= cfg_data[vrt_pkg::CODE_W-1:0];
          vrt_pkg::CFG_FLOOR:  floor_level <= signed'(cfg_data[vrt_pkg::FLOOR_W-1:0]);
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        vrt_pkg::ST_IDLE: begin
          if (accept) begin
            axis <= vrt_pkg::AXIS_X;
          end
        end
        vrt_pkg::ST_MUL: begin
          cur[axis]      <= cell0;
          prev[axis]     <= cell0;
          step_neg[axis] <= head_sel[vrt_pkg::HEADING_W-1];
        end
        vrt_pkg::ST_NEAR_WAIT: begin
          if (div_rsp.done) begin
            // zero heading never crosses on this axis
            next_cross[axis] <= (mag == '0) ? vrt_pkg::CROSS_MAX
                                            : vrt_pkg::sat_cross(div_rsp.quotient);
          end
        end
        vrt_pkg::ST_STEP_WAIT: begin
          if (div_rsp.done) begin
            cross_step[axis] <= (mag == '0) ? vrt_pkg::CROSS_MAX
                                            : vrt_pkg::sat_cross(div_rsp.quotient);
            axis <= axis + 1'b1;
          end
        end
        vrt_pkg::ST_CHECK: begin
          cells_left <= budget;
          if (budget == '0) begin
            awaiting <= 1'b0;
          end
        end
        vrt_pkg::ST_ANSWER: begin
          if (pass) begin
            cells_left <= left_dec;
            for (int i = 0; i < 3; i++) begin
              prev[i] <= cur[i];
            end
            if (left_dec == '0) begin
              awaiting <= 1'b0;
            end
          end else begin
            awaiting <= 1'b0;
          end
        end
        vrt_pkg::ST_ADVANCE: begin
          cur[pick]        <= stepped;
          next_cross[pick] <= cross_new;
          awaiting         <= !below;
        end
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= items.data;
    end

    case (state)
      vrt_pkg::ST_IDLE: begin
        budget <= '0;
      end
      vrt_pkg::ST_MUL: begin
        prod <= head_sel * signed'({1'b0, item.reach});
      end
      vrt_pkg::ST_SPAN: begin
        term <= span[vrt_pkg::DIFF_W-1] ? vrt_pkg::DIFF_W'(-span)
                                        : vrt_pkg::DIFF_W'(span);
      end
      vrt_pkg::ST_NEAR: begin
        // budget saturates at its 17-bit limit
        budget <= (budget_sum > (vrt_pkg::DIFF_W+1)'(vrt_pkg::BUDGET_MAX))
                ? vrt_pkg::BUDGET_MAX : vrt_pkg::BUDGET_W'(budget_sum);
      end
      vrt_pkg::ST_CHECK: begin
        res <= miss_item;
      end
      vrt_pkg::ST_ANSWER: begin
        res <= pass ? miss_item : hit_item;
      end
      vrt_pkg::ST_ADVANCE: begin
        // stepping below the floor ends the walk without a lookup
        res <= below ? miss_item : req_item;
      end
      default: ;
    endcase

    if (out_load) begin
      out_q <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/vrt_divider.sv
// ----------------------------------------------------------------------------
// vrt_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vrt_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vrt_pkg::div_req_t req,
  output vrt_pkg::div_rsp_t      rsp
);

  logic [vrt_pkg::DIVIDEND_W-1:0] acc;
  logic [vrt_pkg::DIVISOR_W-1:0]  rem;
  logic [vrt_pkg::DIVISOR_W-1:0]  divisor_q;
  logic [vrt_pkg::DIV_CNT_W-1:0]  count;
  logic                           busy;
  logic                           done;

  logic [vrt_pkg::DIVISOR_W:0]    shifted;
  logic                           fits;
  logic [vrt_pkg::DIVISOR_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, acc[vrt_pkg::DIVIDEND_W-1]};
    fits     = shifted >= {1'b0, divisor_q};
    rem_next = fits ? vrt_pkg::DIVISOR_W'(shifted - {1'b0, divisor_q})
                    : vrt_pkg::DIVISOR_W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == vrt_pkg::DIV_CNT_W'(vrt_pkg::DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc       <= req.dividend;
      rem       <= '0;
      divisor_q <= req.divisor;
    end else if (busy) begin
      acc <= {acc[vrt_pkg::DIVIDEND_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = acc;

endmodule

`default_nettype wire
